// ===== design/indexed_list_store_macros.svh =====
// Assertion macros used by the indexed list store controller
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define ILS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ils_pkg.sv =====
// Types and constants of the indexed list store
`default_nettype none

package ils_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned OP_W = 3;
  localparam int unsigned POS_W = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned LEN_W = 7;
  localparam int unsigned ST_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_SHIFT   = 3'd2,
    OP_UNSHIFT = 3'd3,
    OP_INSERT  = 3'd4,
    OP_DELETE  = 3'd5,
    OP_CLEAR   = 3'd6,
    OP_SIZE    = 3'd7
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_SMALL = 3'd2,
    ST_LARGE = 3'd3,
    ST_FULL  = 3'd4
  } st_e;

  // row move broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } move_t;

endpackage

`default_nettype wire

// ===== design/indexed_list_store.sv =====
// Top level of the indexed list store: a row of cells with a shared controller
//
//  beat     | ports                                       | handshake
//  ---------+---------------------------------------------+-------------------------
//  command  | opcode_i, position_i, data_in_i             | start high, busy low
//  result   | data_out_o, length_o, status_o              | done_o, one cycle
//
// A new command is taken at every edge; busy stays low.
// The result shows with done_o in the cycle after the command edge.
// Every cell moves at once (hold, load, take left, take right), so the row update
// for insert and delete is done by all cells in parallel; the pop read is one mux over the row.
// Reset clears the count and the result strobe; cell contents are left as they are.
// The receiver cannot stall: each result is valid for exactly one cycle.
`default_nettype none

module indexed_list_store #(
  parameter int unsigned DEPTH = ils_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [ils_pkg::OP_W-1:0]         opcode_i,
  input  logic signed [ils_pkg::POS_W-1:0] position_i,
  input  logic [ils_pkg::WORD_W-1:0]       data_in_i,
  output logic                             done_o,
  output logic [ils_pkg::WORD_W-1:0]       data_out_o,
  output logic [ils_pkg::LEN_W-1:0]        length_o,
  output logic [ils_pkg::ST_W-1:0]         status_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned OW = (DATA_WIDTH > ils_pkg::WORD_W) ? DATA_WIDTH : ils_pkg::WORD_W;

  logic                  accept;
  ils_pkg::move_t        move;
  logic [IW-1:0]         pos;
  logic [OW-1:0]         word_w;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] cells [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign word_w = OW'(data_in_i);
  assign word   = word_w[DATA_WIDTH-1:0];

  ils_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IW         (IW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .opcode_i   (opcode_i),
    .position_i (position_i),
    .cells_i    (cells),
    .move_o     (move),
    .pos_o      (pos),
    .done_o     (done_o),
    .data_out_o (data_out_o),
    .length_o   (length_o),
    .status_o   (status_o)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = word;
    end else begin : g_mid_l
      assign left = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cells[i];
    end else begin : g_mid_r
      assign right = cells[i+1];
    end
    ils_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IW         (IW),
      .IDX        (i)
    ) u_cell (
      .clk_i   (clk_i),
      .move_i  (move),
      .pos_i   (pos),
      .word_i  (word),
      .left_i  (left),
      .right_i (right),
      .data_o  (cells[i])
    );
  end

endmodule

`default_nettype wire

// ===== design/ils_cell.sv =====
// One storage cell of the list row
`default_nettype none

module ils_cell #(
  parameter int unsigned DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF,
  parameter int unsigned IW = $clog2(ils_pkg::DEPTH_DEF),
  parameter int unsigned IDX = 0
) (
  input  logic                  clk_i,
  input  ils_pkg::move_t        move_i,
  input  logic [IW-1:0]         pos_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  at_pos, past_pos;

  assign at_pos   = (MyIdx == pos_i);
  assign past_pos = (MyIdx > pos_i);

  always_comb begin
    data_d = data_q;
    priority if (move_i.ins && at_pos) begin
      data_d = word_i;
    end else if (move_i.ins && past_pos) begin
      data_d = left_i;
    end else if (move_i.del && (at_pos || past_pos)) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== design/ils_ctrl.sv =====
// Count, position check, row move decode and result register
`default_nettype none

module ils_ctrl #(
  parameter int unsigned DEPTH = ils_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF,
  parameter int unsigned IW = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [ils_pkg::OP_W-1:0]     opcode_i,
  input  logic signed [ils_pkg::POS_W-1:0] position_i,
  input  logic [DATA_WIDTH-1:0]        cells_i [DEPTH],
  output ils_pkg::move_t               move_o,
  output logic [IW-1:0]                pos_o,
  output logic                         done_o,
  output logic [ils_pkg::WORD_W-1:0]   data_out_o,
  output logic [ils_pkg::LEN_W-1:0]    length_o,
  output logic [ils_pkg::ST_W-1:0]     status_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = ((CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W) + 1;
  localparam int unsigned OW = (DATA_WIDTH > ils_pkg::WORD_W) ? DATA_WIDTH : ils_pkg::WORD_W;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic [CW-1:0]   count_q, count_d;
  logic            done_q;
  logic [ils_pkg::WORD_W-1:0] dout_q;
  logic [ils_pkg::LEN_W-1:0]  len_q;
  ils_pkg::st_e    stat_q, stat_d;

  logic            full, empty, neg, too_small, ins_large, del_large;
  logic [ils_pkg::POS_W-1:0] pos_u, mag;
  logic [CMPW-1:0] cnt_x, mag_x, pos_x, res_x;
  logic [IW-1:0]   res_idx, last_idx, k;
  logic            ins_c, del_c;
  logic [DATA_WIDTH-1:0] dout_c;
  logic [OW-1:0]   dout_w;
  ils_pkg::op_e    op;
  logic            err_beat;

  assign op      = ils_pkg::op_e'(opcode_i);
  assign full    = (count_q >= DepthC);
  assign empty   = (count_q == '0);
  assign pos_u   = position_i;
  assign neg     = pos_u[ils_pkg::POS_W-1];
  assign mag     = ~pos_u + ils_pkg::POS_W'(1);
  assign cnt_x   = CMPW'(count_q);
  assign mag_x   = CMPW'(mag);
  assign pos_x   = CMPW'(pos_u);
  assign too_small = neg && (mag_x > cnt_x);
  assign ins_large = !neg && (pos_x > cnt_x);
  assign del_large = !neg && (pos_x >= cnt_x);
  assign res_x   = neg ? (cnt_x - mag_x) : pos_x;
  assign res_idx = res_x[IW-1:0];
  assign last_idx = IW'(count_q - CW'(1));

  always_comb begin
    count_d = count_q;
    stat_d  = ils_pkg::ST_OK;
    dout_c  = '0;
    ins_c   = 1'b0;
    del_c   = 1'b0;
    k       = '0;
    unique case (op)
      ils_pkg::OP_PUSH: begin
        if (full) begin
          stat_d = ils_pkg::ST_FULL;
        end else begin
          ins_c   = 1'b1;
          k       = count_q[IW-1:0];
          count_d = count_q + CW'(1);
        end
      end
      ils_pkg::OP_POP: begin
        if (empty) begin
          stat_d = ils_pkg::ST_EMPTY;
        end else begin
          dout_c  = cells_i[last_idx];
          count_d = count_q - CW'(1);
        end
      end
      ils_pkg::OP_SHIFT: begin
        if (empty) begin
          stat_d = ils_pkg::ST_EMPTY;
        end else begin
          dout_c  = cells_i[0];
          del_c   = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      ils_pkg::OP_UNSHIFT: begin
        if (full) begin
          stat_d = ils_pkg::ST_FULL;
        end else begin
          ins_c   = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      ils_pkg::OP_INSERT: begin
        priority if (too_small) begin
          stat_d = ils_pkg::ST_SMALL;
        end else if (ins_large) begin
          stat_d = ils_pkg::ST_LARGE;
        end else if (full) begin
          stat_d = ils_pkg::ST_FULL;
        end else begin
          ins_c   = 1'b1;
          k       = res_idx;
          count_d = count_q + CW'(1);
        end
      end
      ils_pkg::OP_DELETE: begin
        priority if (empty) begin
          stat_d = ils_pkg::ST_EMPTY;
        end else if (too_small) begin
          stat_d = ils_pkg::ST_SMALL;
        end else if (del_large) begin
          stat_d = ils_pkg::ST_LARGE;
        end else begin
          del_c   = 1'b1;
          k       = res_idx;
          count_d = count_q - CW'(1);
        end
      end
      ils_pkg::OP_CLEAR: begin
        count_d = '0;
      end
      ils_pkg::OP_SIZE: begin
        count_d = count_q;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  assign dout_w = OW'(dout_c);

  assign move_o.ins = accept_i && ins_c;
  assign move_o.del = accept_i && del_c;
  assign pos_o      = k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept_i;
      if (accept_i) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      dout_q <= dout_w[ils_pkg::WORD_W-1:0];
      len_q  <= ils_pkg::LEN_W'(count_d);
      stat_q <= stat_d;
    end
  end

  assign done_o     = done_q;
  assign data_out_o = dout_q;
  assign length_o   = len_q;
  assign status_o   = stat_q;

  assign err_beat = done_q && (stat_q != ils_pkg::ST_OK);

`include "indexed_list_store_macros.svh"

  `ILS_ASSERT_NEXT(a_beat_answered, accept_i, done_q, "accepted beat got no result")
  `ILS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= DepthC, "count beyond depth")
  `ILS_ASSERT_NOW(a_err_keeps_count, err_beat, count_q == $past(count_q), "error moved count")
  `ILS_ASSERT_NOW(a_err_zero_data, err_beat, dout_q == '0, "error returned data")
  `ILS_ASSERT_NOW(a_len_matches, done_q, len_q == ils_pkg::LEN_W'(count_q), "length not count")

endmodule

`default_nettype wire
